/* hdl/sbf_pkg.sv */
// Shared types, constants and helper functions of the spectral band feature unit.
`timescale 1ns / 1ps

package sbf_pkg;

   // Field widths fixed by the item formats.
   localparam int INPUT_MAG_W = 16;
   localparam int BIN_WIDTH_W = 20;
   localparam int BAND_HZ_W   = 21;
   localparam int HZ_FRAC_W   = 8;
   localparam int SUM_W       = 48;
   localparam int PEAK_FREQ_W = 29;
   localparam int POWER_MAX_W = 2 * INPUT_MAG_W;

   // Configuration port.
   localparam int CFG_INDEX_W = 3;
   localparam int CFG_DATA_W  = 21;

   // Result queue.
   localparam int FIFO_DEPTH   = 4;
   localparam int FIFO_PTR_W   = 2;
   localparam int FIFO_COUNT_W = 3;

   // Register reset values.
   localparam logic [BIN_WIDTH_W-1:0] BIN_WIDTH_RESET  = 20'd4000;
   localparam logic [BAND_HZ_W-1:0]   BELL_LOW_RESET   = 21'd500;
   localparam logic [BAND_HZ_W-1:0]   BELL_HIGH_RESET  = 21'd2000;
   localparam logic [BAND_HZ_W-1:0]   ALARM_LOW_RESET  = 21'd2900;
   localparam logic [BAND_HZ_W-1:0]   ALARM_HIGH_RESET = 21'd3600;

   // Register indexes of the configuration port.
   typedef enum logic [CFG_INDEX_W-1:0] {
      REG_BIN_WIDTH  = 3'd0,
      REG_BELL_LOW   = 3'd1,
      REG_BELL_HIGH  = 3'd2,
      REG_ALARM_LOW  = 3'd3,
      REG_ALARM_HIGH = 3'd4
   } sbf_reg_type;

   // Live configuration.
   typedef struct packed {
      logic [BIN_WIDTH_W-1:0] bin_width_q8;
      logic [BAND_HZ_W-1:0]   bell_low_hz;
      logic [BAND_HZ_W-1:0]   bell_high_hz;
      logic [BAND_HZ_W-1:0]   alarm_low_hz;
      logic [BAND_HZ_W-1:0]   alarm_high_hz;
   } sbf_cfg_type;

   // One feature result.
   typedef struct packed {
      logic [SUM_W-1:0]       total_power;
      logic [SUM_W-1:0]       bell_power;
      logic [SUM_W-1:0]       alarm_power;
      logic [PEAK_FREQ_W-1:0] peak_freq_q8;
      logic [INPUT_MAG_W-1:0] peak_magnitude;
   } sbf_result_type;

   // Frame ends still travelling through the bin pipeline.
   typedef struct packed {
      logic last_in_a;
      logic last_in_b;
   } sbf_flight_type;

   // Magnitude bits actually used.
   function automatic int mag_width(input int mag_bits);
      return (mag_bits < INPUT_MAG_W) ? mag_bits : INPUT_MAG_W;
   endfunction

   // Bits of the bin counter, which holds values up to the limit minus one.
   function automatic int bin_count_width(input int bin_limit);
      return (bin_limit > 2) ? $clog2(bin_limit) : 1;
   endfunction

   // Accumulator add that sticks at all ones.
   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                input logic [POWER_MAX_W-1:0] power);
      logic [SUM_W:0] sum;
      sum = {1'b0, acc} + (SUM_W + 1)'(power);
      return sum[SUM_W] ? {SUM_W{1'b1}} : sum[SUM_W-1:0];
   endfunction

endpackage

/* hdl/sbf_channels.sv */
// Valid/ready channel interfaces for bin items and feature result items.
`timescale 1ns / 1ps

interface sbf_req_if;
   import sbf_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [INPUT_MAG_W-1:0] bin_magnitude;
   logic                   last_bin;

   modport source (output valid, output bin_magnitude, output last_bin, input ready);
   modport sink   (input valid, input bin_magnitude, input last_bin, output ready);
endinterface

interface sbf_rsp_if;
   import sbf_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [SUM_W-1:0]       total_power;
   logic [SUM_W-1:0]       bell_power;
   logic [SUM_W-1:0]       alarm_power;
   logic [PEAK_FREQ_W-1:0] peak_freq_q8;
   logic [INPUT_MAG_W-1:0] peak_magnitude;

   modport source (output valid, output total_power, output bell_power, output alarm_power,
                   output peak_freq_q8, output peak_magnitude, input ready);
   modport sink   (input valid, input total_power, input bell_power, input alarm_power,
                   input peak_freq_q8, input peak_magnitude, output ready);
endinterface

/* hdl/sbf_front.sv */
// Bin input register, bin counter and the power and frequency multiply stage.
`timescale 1ns / 1ps

module sbf_front #(
   parameter int  BIN_LIMIT = 512,
   parameter int  MAG_BITS  = 16,
   localparam int MAG_W     = sbf_pkg::mag_width(MAG_BITS),
   localparam int BIN_W     = sbf_pkg::bin_count_width(BIN_LIMIT),
   localparam int POW_W     = 2 * MAG_W,
   localparam int FREQ_W    = BIN_W + sbf_pkg::BIN_WIDTH_W
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [sbf_pkg::INPUT_MAG_W-1:0]     bin_magnitude,
   input  logic                                last_bin,
   input  logic [sbf_pkg::BIN_WIDTH_W-1:0]     bin_width_q8,
   output sbf_pkg::sbf_flight_type             flight,
   output logic                                valid_out,
   output logic                                last_out,
   output logic [POW_W-1:0]                    power_out,
   output logic [FREQ_W-1:0]                   freq_out,
   output logic [MAG_W-1:0]                    mag_out
);
   import sbf_pkg::*;

   logic [BIN_W-1:0]  bin_count_ff, bin_count_in;
   logic              valid_a_ff, last_a_ff;
   logic [MAG_W-1:0]  mag_a_ff, mag_a_in;
   logic [BIN_W-1:0]  bin_a_ff;
   logic              valid_b_ff, last_b_ff;
   logic [POW_W-1:0]  power_b_ff, power_b_in;
   logic [FREQ_W-1:0] freq_b_ff, freq_b_in;
   logic [MAG_W-1:0]  mag_b_ff;

   // Bin number of the next item: restarts at one after a frame end, holds at the limit minus one.
   always_comb begin
      bin_count_in = bin_count_ff;
      if (accept) begin
         if (last_bin) begin
            bin_count_in = BIN_W'(1);
         end else if (bin_count_ff < BIN_W'(BIN_LIMIT - 1)) begin
            bin_count_in = bin_count_ff + BIN_W'(1);
         end
      end
   end

   // Only the low magnitude bits take part.
   assign mag_a_in = bin_magnitude[MAG_W-1:0];

   // Power and frequency of the registered bin.
   assign power_b_in = POW_W'(mag_a_ff) * POW_W'(mag_a_ff);
   assign freq_b_in  = FREQ_W'(bin_a_ff) * FREQ_W'(bin_width_q8);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff <= BIN_W'(1);
         valid_a_ff   <= 1'b0;
         valid_b_ff   <= 1'b0;
      end else begin
         bin_count_ff <= bin_count_in;
         valid_a_ff   <= accept;
         valid_b_ff   <= valid_a_ff;
      end
   end

   // Payload registers of both stages.
   always_ff @(posedge clock) begin
      if (accept) begin
         mag_a_ff  <= mag_a_in;
         last_a_ff <= last_bin;
         bin_a_ff  <= bin_count_ff;
      end
      last_b_ff  <= last_a_ff;
      power_b_ff <= power_b_in;
      freq_b_ff  <= freq_b_in;
      mag_b_ff   <= mag_a_ff;
   end

   assign flight.last_in_a = valid_a_ff & last_a_ff;
   assign flight.last_in_b = valid_b_ff & last_b_ff;
   assign valid_out        = valid_b_ff;
   assign last_out         = last_b_ff;
   assign power_out        = power_b_ff;
   assign freq_out         = freq_b_ff;
   assign mag_out          = mag_b_ff;

   // The bin counter stays between one and the limit minus one.
   assert property (@(posedge clock) disable iff (reset)
      (bin_count_ff != '0) && (bin_count_ff <= BIN_W'(BIN_LIMIT - 1)))
      else $error("bin counter out of range");

endmodule

/* hdl/sbf_accum.sv */
// Frame accumulators for total and band power and the peak bin tracker.
`timescale 1ns / 1ps

module sbf_accum #(
   parameter int  BIN_LIMIT = 512,
   parameter int  MAG_BITS  = 16,
   localparam int MAG_W     = sbf_pkg::mag_width(MAG_BITS),
   localparam int BIN_W     = sbf_pkg::bin_count_width(BIN_LIMIT),
   localparam int POW_W     = 2 * MAG_W,
   localparam int FREQ_W    = BIN_W + sbf_pkg::BIN_WIDTH_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    valid_in,
   input  logic                    last_in,
   input  logic [POW_W-1:0]        power_in,
   input  logic [FREQ_W-1:0]       freq_in,
   input  logic [MAG_W-1:0]        mag_in,
   input  sbf_pkg::sbf_cfg_type    cfg,
   output logic                    push,
   output sbf_pkg::sbf_result_type push_data
);
   import sbf_pkg::*;

   localparam int CMP_W = (FREQ_W > PEAK_FREQ_W) ? FREQ_W : PEAK_FREQ_W;

   logic [SUM_W-1:0]       total_acc_ff, total_acc_in;
   logic [SUM_W-1:0]       bell_acc_ff, bell_acc_in;
   logic [SUM_W-1:0]       alarm_acc_ff, alarm_acc_in;
   logic [POW_W-1:0]       best_power_ff, best_power_in;
   logic [PEAK_FREQ_W-1:0] best_freq_ff, best_freq_in;
   logic [MAG_W-1:0]       best_mag_ff, best_mag_in;

   logic [CMP_W-1:0]       freq_cmp;
   logic [CMP_W-1:0]       bell_lo, bell_hi, alarm_lo, alarm_hi;
   logic                   in_bell, in_alarm, take_peak;
   logic [POWER_MAX_W-1:0] power_ext;
   logic [PEAK_FREQ_W-1:0] freq_sat;
   logic [SUM_W-1:0]       total_sum, bell_sum, alarm_sum;
   logic [POW_W-1:0]       peak_power;
   logic [PEAK_FREQ_W-1:0] peak_freq;
   logic [MAG_W-1:0]       peak_mag;

   // Band edges in Q8 Hz against the full bin frequency.
   assign freq_cmp = CMP_W'(freq_in);
   assign bell_lo  = CMP_W'({cfg.bell_low_hz, {HZ_FRAC_W{1'b0}}});
   assign bell_hi  = CMP_W'({cfg.bell_high_hz, {HZ_FRAC_W{1'b0}}});
   assign alarm_lo = CMP_W'({cfg.alarm_low_hz, {HZ_FRAC_W{1'b0}}});
   assign alarm_hi = CMP_W'({cfg.alarm_high_hz, {HZ_FRAC_W{1'b0}}});
   assign in_bell  = (freq_cmp >= bell_lo) && (freq_cmp <= bell_hi);
   assign in_alarm = (freq_cmp >= alarm_lo) && (freq_cmp <= alarm_hi);

   // Peak frequency clips to the result field.
   assign freq_sat = (freq_cmp > CMP_W'({PEAK_FREQ_W{1'b1}})) ? {PEAK_FREQ_W{1'b1}}
                                                               : freq_cmp[PEAK_FREQ_W-1:0];

   // Frame values including the current bin.
   always_comb begin
      power_ext  = POWER_MAX_W'(power_in);
      total_sum  = sat_add(total_acc_ff, power_ext);
      bell_sum   = in_bell ? sat_add(bell_acc_ff, power_ext) : bell_acc_ff;
      alarm_sum  = in_alarm ? sat_add(alarm_acc_ff, power_ext) : alarm_acc_ff;
      take_peak  = power_in > best_power_ff;
      peak_power = take_peak ? power_in : best_power_ff;
      peak_freq  = take_peak ? freq_sat : best_freq_ff;
      peak_mag   = take_peak ? mag_in : best_mag_ff;
   end

   // Keep the running values, or hand them out and clear on a frame end.
   always_comb begin
      total_acc_in  = total_acc_ff;
      bell_acc_in   = bell_acc_ff;
      alarm_acc_in  = alarm_acc_ff;
      best_power_in = best_power_ff;
      best_freq_in  = best_freq_ff;
      best_mag_in   = best_mag_ff;
      if (valid_in) begin
         if (last_in) begin
            total_acc_in  = '0;
            bell_acc_in   = '0;
            alarm_acc_in  = '0;
            best_power_in = '0;
            best_freq_in  = '0;
            best_mag_in   = '0;
         end else begin
            total_acc_in  = total_sum;
            bell_acc_in   = bell_sum;
            alarm_acc_in  = alarm_sum;
            best_power_in = peak_power;
            best_freq_in  = peak_freq;
            best_mag_in   = peak_mag;
         end
      end
   end

   assign push                     = valid_in & last_in;
   assign push_data.total_power    = total_sum;
   assign push_data.bell_power     = bell_sum;
   assign push_data.alarm_power    = alarm_sum;
   assign push_data.peak_freq_q8   = peak_freq;
   assign push_data.peak_magnitude = INPUT_MAG_W'(peak_mag);

   // Accumulator state.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_acc_ff  <= '0;
         bell_acc_ff   <= '0;
         alarm_acc_ff  <= '0;
         best_power_ff <= '0;
         best_freq_ff  <= '0;
         best_mag_ff   <= '0;
      end else begin
         total_acc_ff  <= total_acc_in;
         bell_acc_ff   <= bell_acc_in;
         alarm_acc_ff  <= alarm_acc_in;
         best_power_ff <= best_power_in;
         best_freq_ff  <= best_freq_in;
         best_mag_ff   <= best_mag_in;
      end
   end

   // A frame end leaves every accumulator cleared for the next frame.
   assert property (@(posedge clock) disable iff (reset)
      push |=> (total_acc_ff == '0) && (bell_acc_ff == '0) && (alarm_acc_ff == '0)
               && (best_power_ff == '0))
      else $error("accumulators not cleared after frame end");

   // While no bin with power has been seen, the peak stays empty.
   assert property (@(posedge clock) disable iff (reset)
      (best_power_ff == '0) |-> (best_mag_ff == '0) && (best_freq_ff == '0))
      else $error("peak set without power");

endmodule

/* hdl/sbf_result_fifo.sv */
// Small result queue that drives the result channel.
`timescale 1ns / 1ps

module sbf_result_fifo (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  sbf_pkg::sbf_result_type              push_data,
   output logic [sbf_pkg::FIFO_COUNT_W-1:0]     count,
   sbf_rsp_if.source                            rsp_ch
);
   import sbf_pkg::*;

   sbf_result_type          slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_COUNT_W-1:0] count_ff, count_in;
   logic                    pop;
   sbf_result_type          head;

   assign pop = rsp_ch.valid & rsp_ch.ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + FIFO_COUNT_W'(1);
         2'b01:   count_in = count_ff - FIFO_COUNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The oldest item is shown on the channel.
   assign head                  = slot_ff[rd_ptr_ff];
   assign rsp_ch.valid          = (count_ff != '0);
   assign rsp_ch.total_power    = head.total_power;
   assign rsp_ch.bell_power     = head.bell_power;
   assign rsp_ch.alarm_power    = head.alarm_power;
   assign rsp_ch.peak_freq_q8   = head.peak_freq_q8;
   assign rsp_ch.peak_magnitude = head.peak_magnitude;
   assign count                 = count_ff;

   // Admission control upstream never lets a result arrive at a full queue.
   assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < FIFO_COUNT_W'(FIFO_DEPTH)))
      else $error("result pushed into a full queue");

   // The fill count and the pointers agree.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

endmodule

/* hdl/spectral_band_features_unit.sv */
// Top level of the spectral band feature unit: register file, bin pipeline and result queue.
`timescale 1ns / 1ps

// Usage:
// Bins of one spectrum frame arrive on req_ch, one magnitude per item, starting at bin 1,
// with last_bin set on the final bin. For each frame one item leaves on rsp_ch: total
// power, power in the doorbell and smoke alarm bands, and the frequency and magnitude of
// the strongest bin. Non-final bins produce nothing on rsp_ch.
// Band edges and bin width are written through the csr_ port, one register per cycle
// while no frame is in progress; an index beyond the five registers is ignored.
// Throughput: one bin per cycle while req_ch.ready is high. The path is an input register,
// a multiply stage for power and frequency, and the accumulate stage that writes the result
// queue, so a frame's last bin passes both registers before its result reaches rsp_ch.
// A four-entry result queue decouples the two channels: req_ch.ready depends only on
// registered queue occupancy and frame ends in flight, so a stalled receiver slows the
// input only once four results are waiting or on their way.
// Reset (synchronous) restores the register defaults, empties the queue and restarts
// the bin count at one with cleared accumulators.

module spectral_band_features_unit #(
   parameter int BIN_LIMIT = 512,
   parameter int MAG_BITS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   sbf_req_if.sink                           req_ch,
   sbf_rsp_if.source                         rsp_ch,
   input  logic                              csr_write_en,
   input  logic [sbf_pkg::CFG_INDEX_W-1:0]   csr_index,
   input  logic [sbf_pkg::CFG_DATA_W-1:0]    csr_write_data
);
   import sbf_pkg::*;

   localparam int MAG_W  = mag_width(MAG_BITS);
   localparam int BIN_W  = bin_count_width(BIN_LIMIT);
   localparam int POW_W  = 2 * MAG_W;
   localparam int FREQ_W = BIN_W + BIN_WIDTH_W;

   sbf_cfg_type               cfg_ff, cfg_in;
   logic                      accept;
   sbf_flight_type            flight;
   logic                      bin_valid, bin_last;
   logic [POW_W-1:0]          bin_power;
   logic [FREQ_W-1:0]         bin_freq;
   logic [MAG_W-1:0]          bin_mag;
   logic                      push;
   sbf_result_type            push_data;
   logic [FIFO_COUNT_W-1:0]   fifo_count;
   logic [FIFO_COUNT_W:0]     pending;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (sbf_reg_type'(csr_index))
            REG_BIN_WIDTH:  cfg_in.bin_width_q8  = csr_write_data[BIN_WIDTH_W-1:0];
            REG_BELL_LOW:   cfg_in.bell_low_hz   = csr_write_data[BAND_HZ_W-1:0];
            REG_BELL_HIGH:  cfg_in.bell_high_hz  = csr_write_data[BAND_HZ_W-1:0];
            REG_ALARM_LOW:  cfg_in.alarm_low_hz  = csr_write_data[BAND_HZ_W-1:0];
            REG_ALARM_HIGH: cfg_in.alarm_high_hz = csr_write_data[BAND_HZ_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bin_width_q8  <= BIN_WIDTH_RESET;
         cfg_ff.bell_low_hz   <= BELL_LOW_RESET;
         cfg_ff.bell_high_hz  <= BELL_HIGH_RESET;
         cfg_ff.alarm_low_hz  <= ALARM_LOW_RESET;
         cfg_ff.alarm_high_hz <= ALARM_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Take a bin only when its frame end, if any, is sure of a queue slot.
   assign pending = (FIFO_COUNT_W + 1)'(fifo_count)
                  + (FIFO_COUNT_W + 1)'(flight.last_in_a)
                  + (FIFO_COUNT_W + 1)'(flight.last_in_b);
   assign req_ch.ready = (pending < (FIFO_COUNT_W + 1)'(FIFO_DEPTH));
   assign accept       = req_ch.valid & req_ch.ready;

   sbf_front #(
      .BIN_LIMIT (BIN_LIMIT),
      .MAG_BITS  (MAG_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .bin_magnitude (req_ch.bin_magnitude),
      .last_bin      (req_ch.last_bin),
      .bin_width_q8  (cfg_ff.bin_width_q8),
      .flight        (flight),
      .valid_out     (bin_valid),
      .last_out      (bin_last),
      .power_out     (bin_power),
      .freq_out      (bin_freq),
      .mag_out       (bin_mag)
   );

   sbf_accum #(
      .BIN_LIMIT (BIN_LIMIT),
      .MAG_BITS  (MAG_BITS)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (bin_valid),
      .last_in   (bin_last),
      .power_in  (bin_power),
      .freq_in   (bin_freq),
      .mag_in    (bin_mag),
      .cfg       (cfg_ff),
      .push      (push),
      .push_data (push_data)
   );

   sbf_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .count     (fifo_count),
      .rsp_ch    (rsp_ch)
   );

endmodule

/* verif/testbench.sv */
// Self-checking testbench of the spectral band feature unit: directed table, then random frames.
`timescale 1ns / 1ps

module testbench;
   import sbf_pkg::*;

   localparam int BIN_LIMIT       = 512;
   localparam int MAG_BITS        = 16;
   localparam int SETTLE_CYCLES   = 8;
   localparam int RANDOM_ITEMS    = 360;
   localparam int QUIET_ITEMS     = 100;
   localparam int TIMEOUT_NS      = 4_000_000;

   localparam logic [CFG_DATA_W-1:0]  DATA_MAX = '1;
   localparam logic [PEAK_FREQ_W-1:0] FREQ_MAX = '1;
   localparam logic [INPUT_MAG_W-1:0] MAG_MAX  = '1;

   // Indexes past the five registers; writes there must change nothing.
   localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST  = 3'd7;

   typedef enum logic {ROW_BIN, ROW_WRITE} row_kind_type;

   typedef enum logic [2:0] {
      MAGS_FULL, MAGS_SMALL, MAGS_SPARSE, MAGS_EDGE, MAGS_ZERO
   } mag_style_type;

   // One line of the directed table: a register write or one bin item.
   typedef struct {
      row_kind_type            kind;
      logic [CFG_INDEX_W-1:0]  index;
      logic [CFG_DATA_W-1:0]   data;
      logic [INPUT_MAG_W-1:0]  mag;
      logic                    last;
      bit                      typed;
      sbf_result_type          want;
   } script_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_write_en = 1'b0;
   logic [CFG_INDEX_W-1:0]  csr_index = '0;
   logic [CFG_DATA_W-1:0]   csr_write_data = '0;

   sbf_req_if req_bus ();
   sbf_rsp_if rsp_bus ();

   spectral_band_features_unit #(
      .BIN_LIMIT (BIN_LIMIT),
      .MAG_BITS  (MAG_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_bus),
      .rsp_ch         (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #1 clock = ~clock;

   // Mirror of the block's registers and frame accumulators.
   sbf_cfg_type             band_cfg;
   int unsigned             bin_index;
   logic [SUM_W-1:0]        total_sum;
   logic [SUM_W-1:0]        bell_sum;
   logic [SUM_W-1:0]        alarm_sum;
   logic [POWER_MAX_W-1:0]  peak_power;
   logic [PEAK_FREQ_W-1:0]  peak_freq;
   logic [INPUT_MAG_W-1:0]  peak_mag;

   sbf_result_type          feature_queue[$];
   int                      error_count = 0;
   bit                      send_idle = 1'b0;
   bit                      take_idle = 1'b0;
   int                      stall_left = 0;

   function automatic void clear_frame_state();
      bin_index  = 1;
      total_sum  = '0;
      bell_sum   = '0;
      alarm_sum  = '0;
      peak_power = '0;
      peak_freq  = '0;
      peak_mag   = '0;
   endfunction

   // Sum that sticks at all ones instead of wrapping.
   function automatic logic [SUM_W-1:0] add_capped(input logic [SUM_W-1:0] acc,
                                                   input logic [POWER_MAX_W-1:0] power);
      logic [SUM_W:0] wide;
      wide = (SUM_W + 1)'(acc) + (SUM_W + 1)'(power);
      return wide[SUM_W] ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
   endfunction

   // Folds one bin into the frame; returns 1 with the features when the frame ends.
   function automatic bit fold_bin(input logic [INPUT_MAG_W-1:0] mag_in, input logic last,
                                   output sbf_result_type feat);
      logic [INPUT_MAG_W-1:0] mag;
      logic [POWER_MAX_W-1:0] power;
      logic [63:0]            freq;
      mag   = mag_in & INPUT_MAG_W'((64'd1 << MAG_BITS) - 64'd1);
      power = POWER_MAX_W'(mag) * POWER_MAX_W'(mag);
      freq  = 64'(bin_index) * 64'(band_cfg.bin_width_q8);
      feat  = '0;

      total_sum = add_capped(total_sum, power);
      // Only a strictly larger power moves the peak, so the earliest tie wins.
      if (power > peak_power) begin
         peak_power = power;
         peak_freq  = (freq > 64'(FREQ_MAX)) ? FREQ_MAX : freq[PEAK_FREQ_W-1:0];
         peak_mag   = mag;
      end
      // Band edges are whole Hz, compared against the full Q8 frequency.
      if (freq >= (64'(band_cfg.bell_low_hz) << HZ_FRAC_W) &&
          freq <= (64'(band_cfg.bell_high_hz) << HZ_FRAC_W)) begin
         bell_sum = add_capped(bell_sum, power);
      end
      if (freq >= (64'(band_cfg.alarm_low_hz) << HZ_FRAC_W) &&
          freq <= (64'(band_cfg.alarm_high_hz) << HZ_FRAC_W)) begin
         alarm_sum = add_capped(alarm_sum, power);
      end

      if (!last) begin
         if (bin_index < BIN_LIMIT - 1) begin
            bin_index++;
         end
         return 1'b0;
      end
      feat = '{total_sum, bell_sum, alarm_sum, peak_freq, peak_mag};
      clear_frame_state();
      return 1'b1;
   endfunction

   function automatic script_row_type bin_row(input logic [INPUT_MAG_W-1:0] mag,
                                              input logic last);
      script_row_type row;
      row = '{ROW_BIN, '0, '0, mag, last, 1'b0, '0};
      return row;
   endfunction

   function automatic script_row_type typed_row(input logic [INPUT_MAG_W-1:0] mag,
                                                input sbf_result_type want);
      script_row_type row;
      row = '{ROW_BIN, '0, '0, mag, 1'b1, 1'b1, want};
      return row;
   endfunction

   function automatic script_row_type write_row(input logic [CFG_INDEX_W-1:0] index,
                                                input logic [CFG_DATA_W-1:0] data);
      script_row_type row;
      row = '{ROW_WRITE, index, data, '0, 1'b0, 1'b0, '0};
      return row;
   endfunction

   // Writes one register and keeps the mirror in step, masked to the register width.
   task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                            input logic [CFG_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      case (index)
         REG_BIN_WIDTH:  band_cfg.bin_width_q8  = data[BIN_WIDTH_W-1:0];
         REG_BELL_LOW:   band_cfg.bell_low_hz   = data[BAND_HZ_W-1:0];
         REG_BELL_HIGH:  band_cfg.bell_high_hz  = data[BAND_HZ_W-1:0];
         REG_ALARM_LOW:  band_cfg.alarm_low_hz  = data[BAND_HZ_W-1:0];
         REG_ALARM_HIGH: band_cfg.alarm_high_hz = data[BAND_HZ_W-1:0];
         default: ;
      endcase
   endtask

   // Holds the input off until every pending feature item has come and the pipeline is empty.
   task automatic wait_drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (feature_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Offers one bin, optionally after a gap, and predicts once it is accepted.
   task automatic send_bin(input logic [INPUT_MAG_W-1:0] mag, input logic last,
                           input bit typed, input sbf_result_type want);
      sbf_result_type feat;
      @(negedge clock);
      if (send_idle && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.bin_magnitude <= mag;
      req_bus.last_bin      <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (fold_bin(mag, last, feat)) begin
         feature_queue.push_back(typed ? want : feat);
      end
   endtask

   // One frame of random length with magnitudes drawn in one of several styles.
   task automatic send_random_frame(output int sent);
      int                     len;
      int                     pick;
      mag_style_type          style;
      logic [INPUT_MAG_W-1:0] mag;
      pick = $urandom_range(0, 29);
      if (pick == 0) begin
         len = $urandom_range(60, 200);
      end else if (pick < 4) begin
         len = 1;
      end else begin
         len = $urandom_range(2, 24);
      end
      style = mag_style_type'($urandom_range(0, 4));
      for (int i = 0; i < len; i++) begin
         case (style)
            MAGS_FULL:   mag = INPUT_MAG_W'($urandom);
            MAGS_SMALL:  mag = INPUT_MAG_W'($urandom_range(0, 7));
            MAGS_SPARSE: mag = ($urandom_range(0, 5) == 0) ? INPUT_MAG_W'($urandom) : '0;
            MAGS_EDGE: begin
               case ($urandom_range(0, 3))
                  0:       mag = '0;
                  1:       mag = 16'd1;
                  2:       mag = MAG_MAX - 16'd1;
                  default: mag = MAG_MAX;
               endcase
            end
            default:     mag = '0;
         endcase
         send_bin(mag, i == len - 1, 1'b0, '0);
      end
      sent = len;
   endtask

   // New register settings for a phase; the four modes rotate with the phase number.
   task automatic write_random_config(input int phase);
      logic [CFG_DATA_W-1:0] width;
      logic [CFG_DATA_W-1:0] bell_lo;
      logic [CFG_DATA_W-1:0] bell_hi;
      logic [CFG_DATA_W-1:0] alarm_lo;
      logic [CFG_DATA_W-1:0] alarm_hi;
      int                    span;
      case (phase % 4)
         // Bands sized to land on the bins that frames actually reach.
         0: begin
            width    = CFG_DATA_W'($urandom_range(1, 16000));
            span     = int'(width) * 30 / 256 + 1;
            bell_lo  = CFG_DATA_W'($urandom_range(0, span));
            bell_hi  = bell_lo + CFG_DATA_W'($urandom_range(0, span));
            alarm_lo = CFG_DATA_W'($urandom_range(0, span));
            alarm_hi = alarm_lo + CFG_DATA_W'($urandom_range(0, span));
         end
         // Any value of any bit, bin width bit 20 included.
         1: begin
            width    = CFG_DATA_W'($urandom);
            bell_lo  = CFG_DATA_W'($urandom);
            bell_hi  = CFG_DATA_W'($urandom);
            alarm_lo = CFG_DATA_W'($urandom);
            alarm_hi = CFG_DATA_W'($urandom);
         end
         // Every value at one end of its range.
         2: begin
            width    = $urandom_range(0, 1) ? DATA_MAX : '0;
            bell_lo  = $urandom_range(0, 1) ? DATA_MAX : '0;
            bell_hi  = $urandom_range(0, 1) ? DATA_MAX : '0;
            alarm_lo = $urandom_range(0, 1) ? DATA_MAX : '0;
            alarm_hi = $urandom_range(0, 1) ? DATA_MAX : '0;
         end
         // Narrow bins and low bands, where edges fall between bins.
         default: begin
            width    = CFG_DATA_W'($urandom_range(0, 300));
            bell_lo  = CFG_DATA_W'($urandom_range(0, 10));
            bell_hi  = bell_lo + CFG_DATA_W'($urandom_range(0, 20));
            alarm_lo = CFG_DATA_W'($urandom_range(0, 10));
            alarm_hi = alarm_lo + CFG_DATA_W'($urandom_range(0, 20));
         end
      endcase
      write_reg(REG_BIN_WIDTH, width);
      write_reg(REG_BELL_LOW, bell_lo);
      write_reg(REG_BELL_HIGH, bell_hi);
      write_reg(REG_ALARM_LOW, alarm_lo);
      write_reg(REG_ALARM_HIGH, alarm_hi);
      if ($urandom_range(0, 2) == 0) begin
         write_reg(CFG_INDEX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                   CFG_DATA_W'($urandom));
      end
   endtask

   // Receiver side: ready drops in short random bursts while stalls are enabled.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (take_idle && $urandom_range(0, 4) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = $urandom_range(0, 4);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Each accepted feature item is compared with the oldest prediction.
   always @(posedge clock) begin : check_features
      sbf_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (feature_queue.size() == 0) begin
            $error("feature item arrived with none expected");
            error_count++;
         end else begin
            want = feature_queue.pop_front();
            if (rsp_bus.total_power !== want.total_power) begin
               $error("total_power: expected %0d, got %0d",
                      want.total_power, rsp_bus.total_power);
               error_count++;
            end
            if (rsp_bus.bell_power !== want.bell_power) begin
               $error("bell_power: expected %0d, got %0d", want.bell_power, rsp_bus.bell_power);
               error_count++;
            end
            if (rsp_bus.alarm_power !== want.alarm_power) begin
               $error("alarm_power: expected %0d, got %0d",
                      want.alarm_power, rsp_bus.alarm_power);
               error_count++;
            end
            if (rsp_bus.peak_freq_q8 !== want.peak_freq_q8) begin
               $error("peak_freq_q8: expected %0d, got %0d",
                      want.peak_freq_q8, rsp_bus.peak_freq_q8);
               error_count++;
            end
            if (rsp_bus.peak_magnitude !== want.peak_magnitude) begin
               $error("peak_magnitude: expected %0d, got %0d",
                      want.peak_magnitude, rsp_bus.peak_magnitude);
               error_count++;
            end
         end
      end
   end

   // Main sequence: reset, directed table, random phases, quiet tail.
   initial begin
      script_row_type script[$];
      int             items;
      int             phase;
      int             phase_goal;
      int             sent;

      req_bus.valid         = 1'b0;
      req_bus.bin_magnitude = '0;
      req_bus.last_bin      = 1'b0;
      rsp_bus.ready         = 1'b0;
      band_cfg = '{BIN_WIDTH_RESET, BELL_LOW_RESET, BELL_HIGH_RESET,
                   ALARM_LOW_RESET, ALARM_HIGH_RESET};
      clear_frame_state();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: single-bin frames at the magnitude extremes, ties, all-zero frames.
      script.push_back(typed_row(16'd0, '0));
      script.push_back(typed_row(MAG_MAX, '{48'd4294836225, 48'd0, 48'd0, 29'd4000, MAG_MAX}));
      script.push_back(typed_row(16'd1, '{48'd1, 48'd0, 48'd0, 29'd4000, 16'd1}));
      script.push_back(bin_row(16'd5, 1'b0));
      script.push_back(bin_row(16'd5, 1'b0));
      script.push_back(typed_row(16'd5, '{48'd75, 48'd0, 48'd0, 29'd4000, 16'd5}));
      script.push_back(bin_row(16'd0, 1'b0));
      script.push_back(bin_row(16'd0, 1'b0));
      script.push_back(typed_row(16'd0, '0));
      script.push_back(bin_row(16'd3, 1'b0));
      script.push_back(bin_row(16'd7, 1'b0));
      script.push_back(bin_row(16'd7, 1'b0));
      script.push_back(typed_row(16'd2, '{48'd111, 48'd0, 48'd0, 29'd8000, 16'd7}));
      // One Hz bins, so that bins 2 to 4 sit exactly on the band edges.
      script.push_back(write_row(REG_BIN_WIDTH, 21'd256));
      script.push_back(write_row(REG_BELL_LOW, 21'd2));
      script.push_back(write_row(REG_BELL_HIGH, 21'd3));
      script.push_back(write_row(REG_ALARM_LOW, 21'd3));
      script.push_back(write_row(REG_ALARM_HIGH, 21'd4));
      script.push_back(write_row(REG_SPARE_FIRST, DATA_MAX));
      script.push_back(write_row(REG_SPARE_LAST, '0));
      script.push_back(bin_row(16'd1, 1'b0));
      script.push_back(bin_row(16'd2, 1'b0));
      script.push_back(bin_row(16'd3, 1'b0));
      script.push_back(bin_row(16'd4, 1'b0));
      script.push_back(typed_row(16'd5, '{48'd55, 48'd13, 48'd25, 29'd1280, 16'd5}));
      // Widest bins (the top data bit is dropped), a band over everything, one out of reach.
      script.push_back(write_row(REG_BIN_WIDTH, DATA_MAX));
      script.push_back(write_row(REG_BELL_LOW, '0));
      script.push_back(write_row(REG_BELL_HIGH, DATA_MAX));
      script.push_back(write_row(REG_ALARM_LOW, DATA_MAX));
      script.push_back(write_row(REG_ALARM_HIGH, DATA_MAX));
      script.push_back(bin_row(MAG_MAX, 1'b0));
      script.push_back(bin_row(MAG_MAX - 16'd1, 1'b0));
      script.push_back(bin_row(MAG_MAX, 1'b1));

      send_idle = 1'b1;
      take_idle = 1'b1;
      foreach (script[i]) begin
         if (script[i].kind == ROW_WRITE) begin
            wait_drain();
            write_reg(script[i].index, script[i].data);
         end else begin
            send_bin(script[i].mag, script[i].last, script[i].typed, script[i].want);
         end
      end

      // Random phases, each with fresh registers and its own idling pattern.
      items = 0;
      phase = 0;
      while (items < RANDOM_ITEMS) begin
         wait_drain();
         write_random_config(phase);
         send_idle  = ($urandom_range(0, 3) != 0);
         take_idle  = ($urandom_range(0, 3) != 0);
         phase_goal = items + $urandom_range(40, 90);
         while (items < phase_goal) begin
            if ($urandom_range(0, 7) == 0) begin
               wait_drain();
            end
            send_random_frame(sent);
            items += sent;
         end
         phase++;
      end

      // Closing stretch at full rate on both sides.
      wait_drain();
      write_random_config(0);
      send_idle = 1'b0;
      take_idle = 1'b0;
      items     = 0;
      while (items < QUIET_ITEMS) begin
         send_random_frame(sent);
         items += sent;
      end

      wait_drain();
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // Hang guard well beyond the slowest legal run.
   initial begin
      #(TIMEOUT_NS);
      $display("testbench: errors");
      $finish;
   end

endmodule

/* sim.f */
hdl/sbf_pkg.sv
hdl/sbf_channels.sv
hdl/sbf_front.sv
hdl/sbf_accum.sv
hdl/sbf_result_fifo.sv
hdl/spectral_band_features_unit.sv
verif/testbench.sv
